// ----- hdl/pntp_pkg.sv -----
`timescale 1ns / 1ps

package pntp_pkg;

	// One input beat.
	typedef struct packed {
		logic       req_type;
		logic [7:0] node_id;
		logic [6:0] child_count;
		logic       awake_msg;
		logic       from_neighbor;
	} in_item_t;

	// One result beat.
	typedef struct packed {
		logic [2:0] status;
		logic       send_wait;
		logic       node_muted;
	} out_item_t;

	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_OK        = 3'd1;
	localparam logic [2:0] ST_WARNED    = 3'd2;
	localparam logic [2:0] ST_PENALIZED = 3'd3;
	localparam logic [2:0] ST_UNTRACKED = 3'd4;
	localparam logic [2:0] ST_CLEARED   = 3'd5;

	localparam int CNT_W  = 9;
	localparam int WARN_W = 5;
	localparam int POLY_W = 25;

	localparam logic [CNT_W-1:0]  CNT_MAX  = 9'd511;
	localparam logic [WARN_W-1:0] WARN_MAX = 5'd31;
	localparam logic [3:0]        LIMIT_RESET = 4'd3;

	// Threshold polynomial, every coefficient scaled by 10000.
	localparam logic [POLY_W-1:0] K0    = 25'd2950;
	localparam logic [POLY_W-1:0] K1    = 25'd29400;
	localparam logic [POLY_W-1:0] K2    = 25'd560;
	localparam logic [POLY_W-1:0] K3    = 25'd6;
	localparam logic [POLY_W-1:0] SCALE = 25'd10000;

	// Per-slot counters and mute flag, kept in one memory word.
	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [WARN_W-1:0] warn;
		logic              mute;
	} entry_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_TICK,
		OP_ZERO,
		OP_UPDATE,
		OP_INSERT
	} dp_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_EVAL,
		S_UPDATE,
		S_NOTFOUND,
		S_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic   accept;
		logic   scan;
		logic   capture;
		logic   eval;
		logic   load_out;
		dp_op_t op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic id_zero;
		logic table_empty;
		logic hit;
		logic scan_miss;
	} dp_status_t;

endpackage

// ----- hdl/pntp_ctrl.sv -----
`timescale 1ns / 1ps

module pntp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  pntp_pkg::dp_status_t st,
	output pntp_pkg::ctrl_cmd_t  cmd
);

	pntp_pkg::ctrl_state_t state_q, state_d;
	logic                  out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pntp_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.op  = pntp_pkg::OP_NONE;
		unique case (state_q)
			pntp_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = pntp_pkg::S_DECIDE;
				end
			end
			pntp_pkg::S_DECIDE: begin
				if (st.is_tick) begin
					cmd.op  = pntp_pkg::OP_TICK;
					state_d = pntp_pkg::S_FINISH;
				end else if (st.id_zero) begin
					cmd.op  = pntp_pkg::OP_ZERO;
					state_d = pntp_pkg::S_FINISH;
				end else if (st.table_empty) begin
					state_d = pntp_pkg::S_NOTFOUND;
				end else begin
					state_d = pntp_pkg::S_SCAN;
				end
			end
			pntp_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.hit) begin
					cmd.capture = 1'b1;
					state_d     = pntp_pkg::S_EVAL;
				end else if (st.scan_miss) begin
					state_d = pntp_pkg::S_NOTFOUND;
				end
			end
			pntp_pkg::S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = pntp_pkg::S_UPDATE;
			end
			pntp_pkg::S_UPDATE: begin
				cmd.op  = pntp_pkg::OP_UPDATE;
				state_d = pntp_pkg::S_FINISH;
			end
			pntp_pkg::S_NOTFOUND: begin
				cmd.op  = pntp_pkg::OP_INSERT;
				state_d = pntp_pkg::S_FINISH;
			end
			pntp_pkg::S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = pntp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pntp_pkg::S_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != pntp_pkg::S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- hdl/pntp_dp.sv -----
`timescale 1ns / 1ps

module pntp_dp #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pntp_pkg::in_item_t   in_data,
	input  logic                 cfg_we,
	input  logic [3:0]           cfg_data,
	input  pntp_pkg::ctrl_cmd_t  cmd,
	output pntp_pkg::dp_status_t st,
	output pntp_pkg::out_item_t  out_data
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

	// Slot memories. Slots at or above the fill count are free and their reads are never used.
	logic [7:0]       id_mem  [TABLE_ENTRIES];
	pntp_pkg::entry_t ent_mem [TABLE_ENTRIES];

	pntp_pkg::in_item_t  req_q;
	pntp_pkg::out_item_t res_q, res_d, out_q;
	logic [3:0]          limit_q;
	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       addr_q;
	logic [TABLE_ENTRIES-1:0] cnt_vld_q;

	logic             rd_vld_s1;
	logic [CW-1:0]    rd_idx_s1;
	logic [7:0]       id_rd_s1;
	pntp_pkg::entry_t ent_rd_s1;

	logic [IW-1:0]              slot_q;
	logic [pntp_pkg::CNT_W-1:0]  cnt_inc_q;
	logic [pntp_pkg::CNT_W-1:0]  cnt_old_q;
	logic [pntp_pkg::WARN_W-1:0] warn_q;
	logic                       mute_q;

	logic [7:0]                  x;
	logic [7:0]                  x_s1;
	logic [15:0]                 x2_s1;
	logic [pntp_pkg::POLY_W-1:0] a_s1, a_s2, b_s2, lhs_s3, rhs_s3;
	logic [23:0]                 x3_s2;

	logic                        rd_cnt_vld;
	logic [pntp_pkg::CNT_W-1:0]  rd_cnt;
	logic                        can_add, ins_ok, ent_we;
	logic [IW-1:0]               wr_idx;
	pntp_pkg::entry_t            ent_wd, upd_ent;
	pntp_pkg::out_item_t         upd_res;
	logic                        mute_a, over_thr, penal;
	logic [pntp_pkg::WARN_W-1:0] warn_inc;

	assign x = {1'b0, req_q.child_count} + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= pntp_pkg::LIMIT_RESET;
			fill_q    <= '0;
			addr_q    <= '0;
			cnt_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.accept) begin
				addr_q    <= '0;
				rd_vld_s1 <= 1'b0;
			end else if (cmd.scan) begin
				rd_vld_s1 <= (addr_q < fill_q);
				if (addr_q < fill_q) begin
					addr_q <= addr_q + CW'(1);
				end
			end
			if (cmd.op == pntp_pkg::OP_TICK) begin
				cnt_vld_q <= '0;
			end else if (ins_ok) begin
				cnt_vld_q[fill_q[IW-1:0]] <= 1'b1;
			end else if (cmd.op == pntp_pkg::OP_UPDATE) begin
				cnt_vld_q[slot_q] <= 1'b1;
			end
			if (ins_ok) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	// Memory ports: one read at the scan address, one write.
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			id_rd_s1  <= id_mem[addr_q[IW-1:0]];
			ent_rd_s1 <= ent_mem[addr_q[IW-1:0]];
			rd_idx_s1 <= addr_q;
		end
		if (ins_ok) begin
			id_mem[wr_idx] <= req_q.node_id;
		end
		if (ent_we) begin
			ent_mem[wr_idx] <= ent_wd;
		end
	end

	assign rd_cnt_vld = cnt_vld_q[rd_idx_s1[IW-1:0]];
	assign rd_cnt     = rd_cnt_vld ? ent_rd_s1.cnt : '0;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= in_data;
		end
		if (cmd.capture) begin
			slot_q    <= rd_idx_s1[IW-1:0];
			cnt_inc_q <= (rd_cnt == pntp_pkg::CNT_MAX) ? rd_cnt :
				rd_cnt + pntp_pkg::CNT_W'(1);
			cnt_old_q <= rd_cnt;
			warn_q    <= rd_cnt_vld ? ent_rd_s1.warn : '0;
			mute_q    <= ent_rd_s1.mute;
		end
		// Threshold polynomial, one multiplier level per stage.
		x_s1   <= x;
		x2_s1  <= 16'(x) * 16'(x);
		a_s1   <= pntp_pkg::K1 * pntp_pkg::POLY_W'(x);
		x3_s2  <= 24'(x2_s1) * 24'(x_s1);
		b_s2   <= pntp_pkg::K2 * pntp_pkg::POLY_W'(x2_s1);
		a_s2   <= a_s1;
		if (cmd.eval) begin
			rhs_s3 <= pntp_pkg::K0 + a_s2 + pntp_pkg::K3 * pntp_pkg::POLY_W'(x3_s2);
			lhs_s3 <= pntp_pkg::POLY_W'(cnt_inc_q) * pntp_pkg::SCALE + b_s2;
		end
		if (cmd.op != pntp_pkg::OP_NONE) begin
			res_q <= res_d;
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	// Update of a listed node.
	always_comb begin
		mute_a   = mute_q & ~req_q.awake_msg;
		over_thr = lhs_s3 > rhs_s3;
		warn_inc = (warn_q == pntp_pkg::WARN_MAX) ? warn_q :
			warn_q + pntp_pkg::WARN_W'(1);
		penal    = warn_inc > {1'b0, limit_q};
		upd_ent.cnt  = cnt_inc_q;
		upd_ent.warn = warn_q;
		upd_ent.mute = mute_a;
		upd_res.status     = pntp_pkg::ST_OK;
		upd_res.send_wait  = 1'b0;
		if (!req_q.from_neighbor) begin
			// Counters are written back as read; only the awake flag acts.
			upd_ent.cnt    = cnt_old_q;
			upd_res.status = pntp_pkg::ST_UNTRACKED;
		end else if (over_thr) begin
			upd_ent.cnt = '0;
			if (penal) begin
				upd_ent.warn      = '0;
				upd_ent.mute      = 1'b1;
				upd_res.status    = pntp_pkg::ST_PENALIZED;
				upd_res.send_wait = 1'b1;
			end else begin
				upd_ent.warn   = warn_inc;
				upd_res.status = pntp_pkg::ST_WARNED;
			end
		end
		upd_res.node_muted = upd_ent.mute;
	end

	assign can_add = req_q.from_neighbor && (fill_q != FULL);
	assign ins_ok  = (cmd.op == pntp_pkg::OP_INSERT) && can_add;
	assign ent_we  = ins_ok || (cmd.op == pntp_pkg::OP_UPDATE);
	assign wr_idx  = ins_ok ? fill_q[IW-1:0] : slot_q;
	assign ent_wd  = ins_ok ?
		pntp_pkg::entry_t'{cnt: pntp_pkg::CNT_W'(1), warn: '0, mute: 1'b0} : upd_ent;

	always_comb begin
		res_d = '{status: pntp_pkg::ST_UNTRACKED, send_wait: 1'b0, node_muted: 1'b0};
		unique case (cmd.op)
			pntp_pkg::OP_TICK:   res_d.status = pntp_pkg::ST_CLEARED;
			pntp_pkg::OP_ZERO:   res_d.status = pntp_pkg::ST_UNTRACKED;
			pntp_pkg::OP_UPDATE: res_d = upd_res;
			pntp_pkg::OP_INSERT: begin
				if (can_add) begin
					res_d.status = pntp_pkg::ST_ADDED;
				end
			end
			default: res_d.status = pntp_pkg::ST_UNTRACKED;
		endcase
	end

	always_comb begin
		st.is_tick     = req_q.req_type;
		st.id_zero     = (req_q.node_id == 8'd0);
		st.table_empty = (fill_q == '0);
		st.hit         = rd_vld_s1 && (id_rd_s1 == req_q.node_id);
		st.scan_miss   = rd_vld_s1 && (id_rd_s1 != req_q.node_id) &&
			(rd_idx_s1 == fill_q - CW'(1));
	end

	assign out_data = out_q;

endmodule

// ----- hdl/per_node_traffic_policer.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Beat
// in        input      in_valid / in_stall   one request (report or period tick)
// out       output     out_valid / out_stall one result (status, wait, mute)
// cfg       input      cfg_valid / cfg_ready warning_limit, 4 bits
//
// A listed node's report goes through decode, a scan up to its slot, evaluation and
// write-back; an unlisted node is scanned over the fill count (not on an empty table)
// and goes to the insert step, and period ticks and node id zero go from decode to the result.
// A stalled result holds the next one back only once that one is ready to leave.
// Reset clears the fill count, the per-slot counter valid bits and the controller;
// the slot memories need no clearing pass.
module per_node_traffic_policer #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pntp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output pntp_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [3:0]          cfg_data
);

	pntp_pkg::ctrl_cmd_t  cmd;
	pntp_pkg::dp_status_t st;

	// The limit register is always ready; write it only while idle (unenforced).
	assign cfg_ready = 1'b1;

	// The controller sequences decode, scan, threshold evaluation and
	// write-back, and owns both handshakes.
	pntp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// The datapath holds the slot memories, the counter valid bits, the
	// threshold polynomial pipeline and the result registers.
	pntp_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.st       (st),
		.out_data (out_data)
	);

endmodule

// ----- hdl/pntp_checker.sv -----
`timescale 1ns / 1ps

module pntp_props (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input pntp_pkg::out_item_t out_data
);

	// An accepted request keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken right after an accepted beat");

	// A wait reply goes out only with a penalty.
	a_wait_only_penalty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.send_wait |-> out_data.status == pntp_pkg::ST_PENALIZED)
		else $error("send_wait without penalty");

	// Cleared and added results never report a muted node.
	a_clear_add_unmuted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == pntp_pkg::ST_CLEARED ||
		out_data.status == pntp_pkg::ST_ADDED) |-> !out_data.node_muted)
		else $error("muted flag on cleared or added result");

	// A stalled result stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind per_node_traffic_policer pntp_props u_pntp_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
